// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the top module of the exponentiation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every rising edge of clk_i while reset is released.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Checks that a condition never holds at a rising edge of clk_i.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_PROP(lbl, !(cond))

`else

`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== rtl/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// Montgomery exponentiation package
// Operand widths, word types and register indexes shared by the block.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int OPERAND_BITS = 32;

  typedef logic [OPERAND_BITS-1:0]   word_t;
  typedef logic [2*OPERAND_BITS-1:0] dword_t;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } reg_index_e;

endpackage

// ===== rtl/mme_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// One full-width unsigned multiplier with a registered double-width product.
// ----------------------------------------------------------------------------
module mme_mul
  import mme_pkg::*;
(
  input  logic   clk_i,
  input  word_t  a_i,
  input  word_t  b_i,
  output dword_t prod_o
);

  dword_t prod_q;

  // The product register breaks the path before any following arithmetic.
  always_ff @(posedge clk_i) begin
    prod_q <= dword_t'(a_i) * dword_t'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/montgomery_mod_exp_32_top.sv =====
// ----------------------------------------------------------------------------
// Montgomery modular exponentiation, 32 bit
// Computes base_value ^ exponent mod modulus with Montgomery products.
// ----------------------------------------------------------------------------
// Each input item carries one base value and yields one result item holding
// base_value ^ exponent mod modulus, where modulus and exponent are the two
// configuration registers (index 0 and index 1, both reset to 1). An even or
// zero modulus returns 0 with bad_modulus set; a modulus of 1 returns 0. The
// block works on one item at a time and is not ready while it computes. For a
// valid modulus an item runs through Newton iteration for the modulus inverse,
// modular doubling for R^2 mod modulus, one Montgomery product per set bit
// and per squaring plus the products into and out of Montgomery form, and a
// load of the output register. Each product steps through the states MP_AB,
// MP_M, MP_P and MP_FIN and passes three times through one shared 32 by 32
// bit multiplier. An item with an even or unit modulus skips the arithmetic.
// The finished result sits in an output register, so the next item is
// accepted while it waits.
// ----------------------------------------------------------------------------
module montgomery_mod_exp_32_top
  import mme_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  // Configuration write port.
  input  logic  cfg_we_i,
  input  logic  cfg_index_i,
  input  word_t cfg_wdata_i,
  // Input items.
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  word_t base_value_i,
  // Result items.
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output word_t power_result_o,
  output logic  bad_modulus_o
);

  `include "assert_macros.svh"

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_INV_A  = 4'd1;  // multiply modulus by inverse estimate
  localparam logic [3:0] ST_INV_B  = 4'd2;  // multiply estimate by (2 - n * inv)
  localparam logic [3:0] ST_INV_C  = 4'd3;  // take the refined estimate
  localparam logic [3:0] ST_DBL    = 4'd4;  // modular doubling toward R^2 mod n
  localparam logic [3:0] ST_MP_AB  = 4'd5;  // product t = a * b
  localparam logic [3:0] ST_MP_M   = 4'd6;  // m = t.lo * inv mod R
  localparam logic [3:0] ST_MP_P   = 4'd7;  // p = m * n
  localparam logic [3:0] ST_MP_FIN = 4'd8;  // (t - p) / R, folded into [0, n)
  localparam logic [3:0] ST_DONE   = 4'd9;

  // Montgomery product operations.
  localparam logic [1:0] OP_BM  = 2'd0;  // base into Montgomery form
  localparam logic [1:0] OP_MUL = 2'd1;  // accumulator times base power
  localparam logic [1:0] OP_SQR = 2'd2;  // square the base power
  localparam logic [1:0] OP_OUT = 2'd3;  // accumulator back to normal form

  localparam int          CNT_BITS     = $clog2(2 * OPERAND_BITS);
  localparam int          NEWTON_STEPS = 5;
  localparam logic [CNT_BITS-1:0] NEWTON_LAST = CNT_BITS'(NEWTON_STEPS - 1);
  localparam logic [CNT_BITS-1:0] DBL_R_LAST  = CNT_BITS'(OPERAND_BITS - 1);
  localparam logic [CNT_BITS-1:0] DBL_R2_LAST = CNT_BITS'(2 * OPERAND_BITS - 1);

  // Chooses the next product from the exponent bits that remain.
  function automatic logic [1:0] next_op(word_t bits);
    logic [1:0] op;
    if (bits == '0) begin
      op = OP_OUT;
    end else if (bits[0]) begin
      op = OP_MUL;
    end else begin
      op = OP_SQR;
    end
    return op;
  endfunction

  // Control registers.
  logic [3:0]          state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  word_t               modulus_q, modulus_d;
  word_t               exponent_q, exponent_d;

  // Datapath registers.
  word_t base_q, base_d;
  word_t ebits_q, ebits_d;
  word_t inv_q, inv_d;
  word_t r_q, r_d;
  word_t acc_q, acc_d;
  word_t bm_q, bm_d;
  word_t t_hi_q, t_hi_d;
  logic  bad_q, bad_d;
  word_t result_q, result_d;
  logic  result_bad_q, result_bad_d;

  // Shared multiplier.
  word_t  mul_a, mul_b;
  dword_t prod;

  mme_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  logic in_fire;
  logic out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Modular doubling: r stays below n, so one conditional subtract suffices.
  logic [OPERAND_BITS:0] dbl_two;
  logic [OPERAND_BITS:0] dbl_sub;
  word_t                 dbl_res;

  assign dbl_two = {r_q, 1'b0};
  assign dbl_sub = dbl_two - {1'b0, modulus_q};
  assign dbl_res = dbl_sub[OPERAND_BITS] ? dbl_two[OPERAND_BITS-1:0]
                                         : dbl_sub[OPERAND_BITS-1:0];

  // Montgomery reduction tail. The low halves of t and p agree by the choice
  // of m, so only the high halves are subtracted and a negative result gets n
  // added back.
  logic [OPERAND_BITS:0] mp_diff;
  word_t                 mp_res;

  assign mp_diff = {1'b0, t_hi_q} - {1'b0, prod[2*OPERAND_BITS-1:OPERAND_BITS]};
  assign mp_res  = mp_diff[OPERAND_BITS] ? mp_diff[OPERAND_BITS-1:0] + modulus_q
                                         : mp_diff[OPERAND_BITS-1:0];

  // Multiplier operand selection.
  always_comb begin
    mul_a = modulus_q;
    mul_b = inv_q;
    case (state_q)
      ST_INV_A: begin
        mul_a = modulus_q;
        mul_b = inv_q;
      end
      ST_INV_B: begin
        mul_a = inv_q;
        mul_b = word_t'(2) - prod[OPERAND_BITS-1:0];
      end
      ST_MP_AB: begin
        case (op_q)
          OP_BM: begin
            mul_a = base_q;
            mul_b = r_q;
          end
          OP_MUL: begin
            mul_a = acc_q;
            mul_b = bm_q;
          end
          OP_SQR: begin
            mul_a = bm_q;
            mul_b = bm_q;
          end
          default: begin
            mul_a = acc_q;
            mul_b = word_t'(1);
          end
        endcase
      end
      ST_MP_M: begin
        mul_a = prod[OPERAND_BITS-1:0];
        mul_b = inv_q;
      end
      ST_MP_P: begin
        mul_a = prod[OPERAND_BITS-1:0];
        mul_b = modulus_q;
      end
      default: begin
        mul_a = modulus_q;
        mul_b = inv_q;
      end
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    cnt_d        = cnt_q;
    modulus_d    = modulus_q;
    exponent_d   = exponent_q;
    base_d       = base_q;
    ebits_d      = ebits_q;
    inv_d        = inv_q;
    r_d          = r_q;
    acc_d        = acc_q;
    bm_d         = bm_q;
    t_hi_d       = t_hi_q;
    bad_d        = bad_q;
    result_d     = result_q;
    result_bad_d = result_bad_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    // Writes are to arrive only while the block is idle; the block does not enforce it.
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODULUS:  modulus_d  = cfg_wdata_i;
        REG_EXPONENT: exponent_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          base_d  = base_value_i;
          ebits_d = exponent_q;
          inv_d   = modulus_q;
          r_d     = word_t'(1);
          cnt_d   = '0;
          if (!modulus_q[0]) begin
            acc_d   = '0;
            bad_d   = 1'b1;
            state_d = ST_DONE;
          end else if (modulus_q == word_t'(1)) begin
            acc_d   = '0;
            bad_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            bad_d   = 1'b0;
            state_d = ST_INV_A;
          end
        end
      end
      ST_INV_A: begin
        state_d = ST_INV_B;
      end
      ST_INV_B: begin
        state_d = ST_INV_C;
      end
      ST_INV_C: begin
        inv_d = prod[OPERAND_BITS-1:0];
        if (cnt_q == NEWTON_LAST) begin
          cnt_d   = '0;
          state_d = ST_DBL;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_INV_A;
        end
      end
      ST_DBL: begin
        r_d   = dbl_res;
        cnt_d = cnt_q + 1'b1;
        // After the first half of the doublings r is R mod n, which is 1 in
        // Montgomery form and seeds the accumulator.
        if (cnt_q == DBL_R_LAST) begin
          acc_d = dbl_res;
        end
        if (cnt_q == DBL_R2_LAST) begin
          cnt_d   = '0;
          op_d    = OP_BM;
          state_d = ST_MP_AB;
        end
      end
      ST_MP_AB: begin
        state_d = ST_MP_M;
      end
      ST_MP_M: begin
        t_hi_d  = prod[2*OPERAND_BITS-1:OPERAND_BITS];
        state_d = ST_MP_P;
      end
      ST_MP_P: begin
        state_d = ST_MP_FIN;
      end
      ST_MP_FIN: begin
        state_d = ST_MP_AB;
        case (op_q)
          OP_BM: begin
            bm_d = mp_res;
            op_d = next_op(ebits_q);
          end
          OP_MUL: begin
            acc_d = mp_res;
            // No squaring is needed once the top exponent bit is used.
            op_d  = (ebits_q[OPERAND_BITS-1:1] == '0) ? OP_OUT : OP_SQR;
          end
          OP_SQR: begin
            bm_d    = mp_res;
            ebits_d = ebits_q >> 1;
            op_d    = next_op(ebits_q >> 1);
          end
          default: begin
            acc_d   = mp_res;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (out_load) begin
          result_d     = acc_q;
          result_bad_d = bad_q;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_BM;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      modulus_q   <= word_t'(1);
      exponent_q  <= word_t'(1);
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      modulus_q   <= modulus_d;
      exponent_q  <= exponent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    ebits_q      <= ebits_d;
    inv_q        <= inv_d;
    r_q          <= r_d;
    acc_q        <= acc_d;
    bm_q         <= bm_d;
    t_hi_q       <= t_hi_d;
    bad_q        <= bad_d;
    result_q     <= result_d;
    result_bad_q <= result_bad_d;
  end

  assign out_valid_o    = out_valid_q;
  assign power_result_o = result_q;
  assign bad_modulus_o  = result_bad_q;

  // An item with an even modulus skips all arithmetic.
  `ASSERT_PROP(a_even_skips, (in_fire && !modulus_q[0]) |=> (state_q == ST_DONE))
  // The doubling remainder is always reduced.
  `ASSERT_PROP(a_dbl_reduced, (state_q == ST_DBL) |-> (r_q < modulus_q))
  // Every Montgomery product lands in [0, n).
  `ASSERT_PROP(a_mp_reduced, (state_q == ST_MP_FIN) |-> (mp_res < modulus_q))
  // A result is never loaded over one that is still waiting.
  `ASSERT_NEVER(a_no_overwrite, out_load && out_valid_q && !out_ready_i)

endmodule
